@@ hdl/kinematic_feasible_envelope_assert.svh @@
// Assertion macros shared by the checker of the kinematic envelope block.
// Depends on nothing; included by the checker file.
`ifndef KINEMATIC_FEASIBLE_ENVELOPE_ASSERT_SVH
`define KINEMATIC_FEASIBLE_ENVELOPE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define KFE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define KFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define KFE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/kfe_pkg.sv @@
// Shared types, constants and the saturation helper for the kinematic envelope.
// Depends on nothing; used by the interfaces, the top level and the checker.
package kfe_pkg;

  localparam int POS_W     = 32;
  localparam int SPEED_W   = 31;
  localparam int TIME_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int SAT_IN_W  = 96;

  localparam logic signed [POS_W-1:0] POS_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN  = 32'sh8000_0000;
  localparam logic [TIME_W-1:0]       TIME_MAX = 31'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POSITION = 3'd0,
    REG_START_SPEED    = 3'd1,
    REG_ACCEL_UPPER    = 3'd2,
    REG_ACCEL_LOWER    = 3'd3,
    REG_BASE_SPEED     = 3'd4
  } cfg_reg_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
    logic signed [POS_W-1:0] r;
    if (x > SAT_IN_W'(POS_MAX)) begin
      r = POS_MAX;
    end else if (x < SAT_IN_W'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = x[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/kfe_if.sv @@
// Valid/ready channel interfaces for queries and results of the kinematic envelope.
// Depends on kfe_pkg for field widths.
interface kfe_query_if;
  logic                              valid;
  logic                              ready;
  logic [kfe_pkg::TIME_W-1:0]        query_time;
  logic signed [kfe_pkg::POS_W-1:0]  query_position;

  modport source (output valid, output query_time, output query_position, input ready);
  modport sink   (input valid, input query_time, input query_position, output ready);
endinterface

interface kfe_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [kfe_pkg::POS_W-1:0]  pos_upper;
  logic signed [kfe_pkg::POS_W-1:0]  pos_lower;
  logic signed [kfe_pkg::POS_W-1:0]  speed_upper;
  logic signed [kfe_pkg::POS_W-1:0]  speed_lower;
  logic signed [kfe_pkg::POS_W-1:0]  comfort_speed_upper;
  logic signed [kfe_pkg::POS_W-1:0]  comfort_speed_lower;
  logic [kfe_pkg::TIME_W-1:0]        time_to_reach;
  logic                              behind_start;

  modport source (output valid, output pos_upper, output pos_lower, output speed_upper,
                  output speed_lower, output comfort_speed_upper,
                  output comfort_speed_lower, output time_to_reach, output behind_start,
                  input ready);
  modport sink   (input valid, input pos_upper, input pos_lower, input speed_upper,
                  input speed_lower, input comfort_speed_upper,
                  input comfort_speed_lower, input time_to_reach, input behind_start,
                  output ready);
endinterface

@@ hdl/kinematic_feasible_envelope.sv @@
// Kinematic feasible envelope: position, speed and arrival-time bounds per query.
// Depends on kfe_pkg and the channel interfaces in kfe_if.sv.
//
//   channel   direction  payload
//   query     in         query_time, query_position
//   result    out        six bounds, time_to_reach, behind_start
//   cfg       in         cfg_write, cfg_index, cfg_data
//
// One query enters per cycle unless a stall on the result side has filled every stage.
// The pipeline depth is set by the 33-step square root followed by the 31-step divider.
// Every stage holds its item when the stage after it is full and stalled,
// so a stall on the result side fills bubbles first and loses nothing.
// Reset is synchronous; it clears the stage valid bits and loads the configuration defaults.
module kinematic_feasible_envelope #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kfe_pkg::CFG_W-1:0]       cfg_data,
  kfe_query_if.sink                       query,
  kfe_result_if.source                    result
);

  localparam int SQ_FIRST = 3;
  localparam int SQ_LAST  = 35;
  localparam int TD_INIT  = 36;
  localparam int TD_FIRST = 37;
  localparam int TD_LAST  = 67;
  localparam int N_ST     = 68;
  localparam int WUW      = 62 - FRAC_BITS;
  localparam int PHW      = 31 + WUW - 32;
  localparam int PUW      = 31 + WUW;
  localparam int R2W      = (33 + FRAC_BITS > 62) ? 33 + FRAC_BITS : 62;

  typedef struct packed {
    logic [30:0]        t;
    logic signed [31:0] q;
    logic               behind;
    logic [61:0]        at;
    logic [62:0]        dt;
    logic [61:0]        vv;
    logic [62:0]        ads;
    logic               stopped;
    logic [WUW-1:0]     wup;
    logic [30:0]        wlo;
    logic signed [31:0] vu;
    logic signed [31:0] vl;
    logic signed [31:0] cu;
    logic signed [31:0] cl;
    logic [PUW-1:0]     pup;
    logic [61:0]        plo;
    logic signed [31:0] pu;
    logic signed [31:0] plr;
    logic signed [31:0] pl;
    logic [65:0]        sx;
    logic [32:0]        sr;
    logic [61:0]        r1;
    logic [32:0]        q1;
    logic               ov1;
    logic [R2W-1:0]     r2;
    logic [30:0]        q2;
    logic               ov2;
    logic [30:0]        tt;
  } stage_t;

  logic signed [31:0] start_position;
  logic [30:0]        start_speed;
  logic [30:0]        accel_upper;
  logic signed [31:0] accel_lower;
  logic [30:0]        base_speed;
  logic [30:0]        a_eff;
  logic [31:0]        d_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      start_speed    <= '0;
      accel_upper    <= 31'(1) << FRAC_BITS;
      accel_lower    <= 32'(0) - (32'(1) << FRAC_BITS);
      base_speed     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        kfe_pkg::REG_START_POSITION: start_position <= cfg_data;
        kfe_pkg::REG_START_SPEED:    start_speed    <= cfg_data[30:0];
        kfe_pkg::REG_ACCEL_UPPER:    accel_upper    <= cfg_data[30:0];
        kfe_pkg::REG_ACCEL_LOWER:    accel_lower    <= cfg_data;
        kfe_pkg::REG_BASE_SPEED:     base_speed     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign a_eff = (accel_upper == '0) ? 31'd1 : accel_upper;
  assign d_eff = accel_lower[31] ? 32'(0) - accel_lower : 32'd1;

  stage_t st  [1:N_ST];
  logic   vld [1:N_ST];
  logic   en  [1:N_ST+1];
  stage_t head;

  always_comb begin
    head   = '0;
    head.t = query.query_time;
    head.q = query.query_position;
  end

  assign en[N_ST+1] = result.ready;
  assign query.ready = en[1];

  for (genvar j = 1; j <= N_ST; j++) begin : g_st
    localparam int SQB = (j >= SQ_FIRST && j <= SQ_LAST) ? SQ_LAST - j : 0;
    localparam int TDK = (j >= TD_FIRST && j <= TD_LAST) ? TD_LAST - j : 0;

    stage_t prv;
    stage_t nx;
    logic   pv;

    if (j == 1) begin : g_in
      assign prv = head;
      assign pv  = query.valid;
    end else begin : g_mid
      assign prv = st[j-1];
      assign pv  = vld[j-1];
    end

    assign en[j] = !vld[j] || en[j+1];

    always_comb begin
      logic signed [32:0] dsw;
      logic [95:0]        ceil_f;
      logic [95:0]        ceil_g;
      logic [66:0]        trial_sq;
      logic [65:0]        trial_d1;
      logic [R2W-1:0]     trial_td;
      logic [62:0]        plo32;
      logic [PHW-1:0]     phi;
      logic [32:0]        diff_r;
      dsw      = '0;
      ceil_f   = '0;
      ceil_g   = '0;
      trial_sq = '0;
      trial_d1 = '0;
      trial_td = '0;
      plo32    = '0;
      phi      = '0;
      diff_r   = '0;
      nx       = prv;
      if (j == 1) begin
        dsw       = 33'(prv.q) - 33'(start_position);
        nx.behind = prv.q < start_position;
        nx.at     = a_eff * prv.t;
        nx.dt     = d_eff * prv.t;
        nx.vv     = start_speed * start_speed;
        nx.ads    = a_eff * dsw[31:0];
      end
      if (j == 2) begin
        ceil_f     = (96'(prv.dt) + (96'(1) << FRAC_BITS) - 96'(1)) >> FRAC_BITS;
        ceil_g     = (96'(prv.dt) + (96'(1) << (FRAC_BITS + 1)) - 96'(1)) >> (FRAC_BITS + 1);
        nx.stopped = 96'(prv.dt) >= (96'(start_speed) << FRAC_BITS);
        nx.wup     = WUW'(start_speed) + WUW'(prv.at >> (FRAC_BITS + 1));
        nx.wlo     = ceil_g > 96'(start_speed) ? '0 : 31'(96'(start_speed) - ceil_g);
        nx.vu      = kfe_pkg::sat32(96'($signed({1'b0, start_speed}))
                                    + 96'($signed({1'b0, prv.at >> FRAC_BITS})));
        nx.cu      = kfe_pkg::sat32(96'($signed({1'b0, start_speed}))
                                    + 96'($signed({1'b0, prv.at >> (FRAC_BITS + 1)})));
        nx.vl      = kfe_pkg::sat32($signed(96'(start_speed) - ceil_f));
        nx.cl      = kfe_pkg::sat32($signed(96'(start_speed) - ceil_g));
        nx.sx      = 66'(prv.vv) + (66'(prv.ads) << 1);
        nx.sr      = '0;
        nx.r1      = prv.vv;
        nx.q1      = '0;
        nx.ov1     = 66'(prv.vv) >= (66'({d_eff, 1'b0}) << 33);
      end
      if (j >= SQ_FIRST && j <= SQ_LAST) begin
        trial_sq = (67'(prv.sr) << (SQB + 1)) + (67'(1) << (2 * SQB));
        if (67'(prv.sx) >= trial_sq) begin
          nx.sx = prv.sx - 66'(trial_sq);
          nx.sr = prv.sr | (33'(1) << SQB);
        end
        trial_d1 = 66'({d_eff, 1'b0}) << SQB;
        if (66'(prv.r1) >= trial_d1) begin
          nx.r1 = prv.r1 - 62'(trial_d1);
          nx.q1 = prv.q1 | (33'(1) << SQB);
        end
      end
      if (j == 3) begin
        plo32  = prv.t * prv.wup[31:0];
        phi    = prv.t * prv.wup[WUW-1:32];
        nx.pup = (PUW'(phi) << 32) + PUW'(plo32);
        nx.plo = prv.t * prv.wlo;
      end
      if (j == 4) begin
        nx.pu  = kfe_pkg::sat32(96'($signed({1'b0, prv.pup >> FRAC_BITS}))
                                + 96'(start_position));
        nx.plr = kfe_pkg::sat32(96'($signed({1'b0, prv.plo >> FRAC_BITS}))
                                + 96'(start_position));
      end
      if (j == TD_INIT) begin
        diff_r = (prv.sr > 33'(start_speed)) ? prv.sr - 33'(start_speed) : '0;
        nx.r2  = R2W'(diff_r) << FRAC_BITS;
        nx.ov2 = (R2W'(diff_r) << FRAC_BITS) >= (R2W'(a_eff) << 31);
        nx.q2  = '0;
      end
      if (j >= TD_FIRST && j <= TD_LAST) begin
        trial_td = R2W'(a_eff) << TDK;
        if (prv.r2 >= trial_td) begin
          nx.r2 = prv.r2 - trial_td;
          nx.q2 = prv.q2 | (31'(1) << TDK);
        end
      end
      if (j == N_ST) begin
        if (prv.behind) begin
          nx.tt = '0;
        end else if (prv.ov2) begin
          nx.tt = kfe_pkg::TIME_MAX;
        end else begin
          nx.tt = prv.q2;
        end
        if (prv.stopped) begin
          nx.pl = prv.ov1 ? kfe_pkg::POS_MAX
                          : kfe_pkg::sat32(96'($signed({1'b0, prv.q1}))
                                           + 96'(start_position));
          nx.vl = $signed({1'b0, base_speed});
          nx.cl = $signed({1'b0, base_speed});
        end else begin
          nx.pl = prv.plr;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en[j]) begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j] <= nx;
      end
    end
  end

  assign result.valid               = vld[N_ST];
  assign result.pos_upper           = st[N_ST].pu;
  assign result.pos_lower           = st[N_ST].pl;
  assign result.speed_upper         = st[N_ST].vu;
  assign result.speed_lower         = st[N_ST].vl;
  assign result.comfort_speed_upper = st[N_ST].cu;
  assign result.comfort_speed_lower = st[N_ST].cl;
  assign result.time_to_reach       = st[N_ST].tt;
  assign result.behind_start        = st[N_ST].behind;

endmodule

@@ hdl/kfe_checker.sv @@
// Port-level checker for the kinematic envelope, bound to the top level.
// Depends on kfe_pkg and kinematic_feasible_envelope_assert.svh.
`include "kinematic_feasible_envelope_assert.svh"

module kfe_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [kfe_pkg::POS_W-1:0] pos_upper,
  input logic signed [kfe_pkg::POS_W-1:0] speed_upper,
  input logic signed [kfe_pkg::POS_W-1:0] comfort_speed_upper,
  input logic [kfe_pkg::TIME_W-1:0]       time_to_reach,
  input logic                             behind_start
);

  // A result held back by the sink stays valid and keeps its upper position and arrival time.
  `KFE_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pos_upper) && $stable(time_to_reach), "stalled result changed")

  // Nothing is offered right after reset.
  `KFE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result valid after reset")

  // A target behind the start gives zero arrival time.
  `KFE_ASSERT_NOW(a_behind_zero, clk, rst, out_valid && behind_start, time_to_reach == '0, "behind start with nonzero time")

  // Full acceleration never gives less speed than the comfort limit.
  `KFE_ASSERT_NOW(a_comfort_le, clk, rst, out_valid, speed_upper >= comfort_speed_upper, "comfort speed above upper speed")

endmodule

bind kinematic_feasible_envelope kfe_checker u_kfe_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (result.valid),
  .out_ready           (result.ready),
  .pos_upper           (result.pos_upper),
  .speed_upper         (result.speed_upper),
  .comfort_speed_upper (result.comfort_speed_upper),
  .time_to_reach       (result.time_to_reach),
  .behind_start        (result.behind_start)
);
